// ===== rtl/sensor_reading_threshold_monitor_macros.svh =====
// Assertion macros shared by the sensor threshold monitor RTL.
// Each macro samples on clock and is muted while reset is high.
`ifndef SENSOR_READING_THRESHOLD_MONITOR_MACROS_SVH
`define SENSOR_READING_THRESHOLD_MONITOR_MACROS_SVH

// property must hold at every edge outside reset
`define SRTM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define SRTM_ASSERT_NEVER(lbl, cond, msg) \
   `SRTM_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/srtm_pkg.sv =====
// Shared types and constants for the sensor threshold monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srtm_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int GAIN_W     = 32;
   localparam int VALUE_W    = 48;
   localparam int HYST_W     = 47;
   localparam int RAW_W      = 32;
   localparam int READ_W     = RAW_W + 1;   // widened reading, signed
   localparam int PROD_W     = 64;
   localparam int ALARMS     = 4;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;

   localparam int ALM_WARN_HIGH = 0;
   localparam int ALM_WARN_LOW  = 1;
   localparam int ALM_CRIT_HIGH = 2;
   localparam int ALM_CRIT_LOW  = 3;

   // alarms that trip on the high side
   localparam logic [ALARMS-1:0] HIGH_MASK = 4'b0101;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_BITS;

   // queue between front and back end (power of two)
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN      = 3'd0,
      CSR_BIAS      = 3'd1,
      CSR_HYST      = 3'd2,
      CSR_WARN_HIGH = 3'd3,
      CSR_WARN_LOW  = 3'd4,
      CSR_CRIT_HIGH = 3'd5,
      CSR_CRIT_LOW  = 3'd6,
      CSR_ENABLE    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DECODE = 2'd1,
      ST_COMPL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RS_OK    = 2'd0,
      RS_DECODE = 2'd1,
      RS_COMPL = 2'd2,
      RS_RSVD  = 2'd3
   } resp_code_type;

   typedef enum logic [1:0] {
      OP_ENABLED  = 2'd0,
      OP_DISABLED = 2'd1,
      OP_UNAVAIL  = 2'd2,
      OP_UNAVAIL2 = 2'd3
   } op_state_type;

   typedef enum logic [2:0] {
      SZ_U8  = 3'd0,
      SZ_S8  = 3'd1,
      SZ_U16 = 3'd2,
      SZ_S16 = 3'd3,
      SZ_U32 = 3'd4,
      SZ_S32 = 3'd5,
      SZ_BAD6 = 3'd6,
      SZ_BAD7 = 3'd7
   } size_type;

   typedef enum logic [2:0] {
      KIND_COMPL    = 3'd0,
      KIND_DECERR   = 3'd1,
      KIND_DISABLED = 3'd2,
      KIND_UNAVAIL  = 3'd3,
      KIND_BADSIZE  = 3'd4,
      KIND_CONVERT  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [1:0]       response_status;
      logic [1:0]       operational_state;
      logic [2:0]       data_size;
      logic [RAW_W-1:0] reading_raw;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic                       available;
      logic                       functional;
      logic                       value_valid;
      logic signed [VALUE_W-1:0]  value;
      logic                       warn_high_alarm;
      logic                       warn_low_alarm;
      logic                       crit_high_alarm;
      logic                       crit_low_alarm;
      logic [ALARMS-1:0]          alarm_changed;
   } rsp_type;

   // classified item handed from front to back end
   typedef struct packed {
      kind_type                  kind;
      logic signed [READ_W-1:0]  reading;
   } cmd_type;

endpackage

// ===== rtl/srtm_front.sv =====
// Front end: classifies each request and widens the raw reading by size code.
// Depends on srtm_pkg; feeds srtm_queue.
`timescale 1ns / 1ps

module srtm_front (
   input  logic              req_push,
   input  srtm_pkg::req_type req_data,
   output logic              req_full,
   output logic              q_push,
   output srtm_pkg::cmd_type q_data,
   input  logic              q_full
);
   import srtm_pkg::*;

   logic [RAW_W-1:0] raw;

   assign raw      = req_data.reading_raw;
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   always_comb begin
      unique case (resp_code_type'(req_data.response_status))
         RS_COMPL:          q_data.kind = KIND_COMPL;
         RS_DECODE, RS_RSVD: q_data.kind = KIND_DECERR;
         RS_OK: begin
            unique case (op_state_type'(req_data.operational_state))
               OP_DISABLED:             q_data.kind = KIND_DISABLED;
               OP_UNAVAIL, OP_UNAVAIL2: q_data.kind = KIND_UNAVAIL;
               OP_ENABLED: begin
                  if (req_data.data_size > 3'(SZ_S32)) begin
                     q_data.kind = KIND_BADSIZE;
                  end else begin
                     q_data.kind = KIND_CONVERT;
                  end
               end
               default: q_data.kind = KIND_UNAVAIL;
            endcase
         end
         default: q_data.kind = KIND_DECERR;
      endcase

      unique case (size_type'(req_data.data_size))
         SZ_U8:   q_data.reading = signed'(READ_W'(raw[7:0]));
         SZ_S8:   q_data.reading = READ_W'(signed'(raw[7:0]));
         SZ_U16:  q_data.reading = signed'(READ_W'(raw[15:0]));
         SZ_S16:  q_data.reading = READ_W'(signed'(raw[15:0]));
         SZ_U32:  q_data.reading = signed'(READ_W'(raw));
         default: q_data.reading = READ_W'(signed'(raw));
      endcase
   end

endmodule

// ===== rtl/srtm_queue.sv =====
// Short first-word-fall-through queue of classified items between front and back.
// Depends on srtm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sensor_reading_threshold_monitor_macros.svh"

module srtm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srtm_pkg::cmd_type push_data,
   output logic              full,
   output logic              cmd_valid,
   output srtm_pkg::cmd_type cmd_data,
   input  logic              pop
);
   import srtm_pkg::*;

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = count_ff == CMD_CNT_W'(CMD_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SRTM_ASSERT_NEVER(a_q_pop_empty, pop && !cmd_valid, "back end popped an empty queue")
   `SRTM_ASSERT(a_q_bound, count_ff <= CMD_CNT_W'(CMD_DEPTH), "queue count beyond depth")
   `SRTM_ASSERT(a_q_grow, (push && !full && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count did not grow on a lone push")

endmodule

// ===== rtl/srtm_back.sv =====
// Back end: scaling pipeline, hysteresis alarms, sensor flags, result queue
// and the configuration registers. Depends on srtm_pkg and the macro header.
`timescale 1ns / 1ps
`include "sensor_reading_threshold_monitor_macros.svh"

module srtm_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   input  srtm_pkg::cmd_type                    cmd_data,
   output logic                                 cmd_pop,
   input  logic                                 csr_valid,
   input  srtm_pkg::csr_index_type              csr_index,
   input  logic [srtm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output srtm_pkg::rsp_type                    rsp_data
);
   import srtm_pkg::*;

   localparam int CLAMP_W   = 63;
   localparam int SUM_W     = 64;
   localparam int CMP_W     = VALUE_W + 1;
   localparam int RES_DEPTH = 8;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   localparam logic signed [PROD_W-1:0] PROD_LIM = PROD_W'(1) <<< 61;
   localparam logic signed [SUM_W-1:0]  SUM_MAX  = (SUM_W'(1) <<< (VALUE_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0]  SUM_MIN  = -SUM_MAX - SUM_W'(1);

   // configuration
   logic signed [GAIN_W-1:0]  gain_ff;
   logic signed [VALUE_W-1:0] bias_ff;
   logic [HYST_W-1:0]         hyst_ff;
   logic signed [VALUE_W-1:0] level_ff [ALARMS];
   logic [ALARMS-1:0]         enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         bias_ff   <= '0;
         hyst_ff   <= '0;
         enable_ff <= '0;
         for (int i = 0; i < ALARMS; i++) begin
            level_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:      gain_ff <= signed'(csr_wdata[GAIN_W-1:0]);
            CSR_BIAS:      bias_ff <= signed'(csr_wdata[VALUE_W-1:0]);
            CSR_HYST:      hyst_ff <= csr_wdata[HYST_W-1:0];
            CSR_WARN_HIGH: level_ff[ALM_WARN_HIGH] <= signed'(csr_wdata[VALUE_W-1:0]);
            CSR_WARN_LOW:  level_ff[ALM_WARN_LOW]  <= signed'(csr_wdata[VALUE_W-1:0]);
            CSR_CRIT_HIGH: level_ff[ALM_CRIT_HIGH] <= signed'(csr_wdata[VALUE_W-1:0]);
            CSR_CRIT_LOW:  level_ff[ALM_CRIT_LOW]  <= signed'(csr_wdata[VALUE_W-1:0]);
            CSR_ENABLE:    enable_ff <= csr_wdata[ALARMS-1:0];
         endcase
      end
   end

   // issue credit: items in the pipe plus entries in the result queue
   logic [RES_CNT_W-1:0] held_ff, held_in;
   logic                 res_pop;

   assign cmd_pop = cmd_valid && (held_ff < RES_CNT_W'(RES_DEPTH));
   assign res_pop = rsp_pop && !rsp_empty;

   always_comb begin
      held_in = held_ff + RES_CNT_W'(cmd_pop) - RES_CNT_W'(res_pop);
   end

   // pipeline valids
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         held_ff   <= held_in;
         s1_vld_ff <= cmd_pop;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // stage 1: multiply by gain
   kind_type                  s1_kind_ff, s2_kind_ff, s3_kind_ff, s4_kind_ff;
   logic signed [PROD_W-1:0]  s1_prod_ff, s1_prod_in;
   logic signed [CLAMP_W-1:0] s2_clamp_ff, s2_clamp_in;
   logic signed [SUM_W-1:0]   s3_sum;
   logic signed [VALUE_W-1:0] s3_value_ff, s3_value_in;
   logic signed [VALUE_W-1:0] s4_value_ff;
   logic [ALARMS-1:0]         s4_set_ff, s4_set_in;
   logic [ALARMS-1:0]         s4_clr_ff, s4_clr_in;

   assign s1_prod_in = PROD_W'(cmd_data.reading) * PROD_W'(gain_ff);

   // stage 2: clamp product to +/- 2^61
   always_comb begin
      if (s1_prod_ff > PROD_LIM) begin
         s2_clamp_in = CLAMP_W'(PROD_LIM);
      end else if (s1_prod_ff < -PROD_LIM) begin
         s2_clamp_in = CLAMP_W'(-PROD_LIM);
      end else begin
         s2_clamp_in = CLAMP_W'(s1_prod_ff);
      end
   end

   // stage 3: add bias, saturate to 48 bits
   assign s3_sum = SUM_W'(s2_clamp_ff) + SUM_W'(bias_ff);

   always_comb begin
      if (s3_sum > SUM_MAX) begin
         s3_value_in = VALUE_W'(SUM_MAX);
      end else if (s3_sum < SUM_MIN) begin
         s3_value_in = VALUE_W'(SUM_MIN);
      end else begin
         s3_value_in = VALUE_W'(s3_sum);
      end
   end

   // stage 4: threshold compares, independent of alarm state
   logic signed [CMP_W-1:0] v_ext, hyst_ext;
   logic signed [CMP_W-1:0] lvl_ext [ALARMS];

   assign v_ext    = CMP_W'(s3_value_ff);
   assign hyst_ext = signed'({2'b00, hyst_ff});

   always_comb begin
      for (int i = 0; i < ALARMS; i++) begin
         lvl_ext[i] = CMP_W'(level_ff[i]);
         if (HIGH_MASK[i]) begin
            s4_set_in[i] = v_ext >= lvl_ext[i];
            s4_clr_in[i] = v_ext < (lvl_ext[i] - hyst_ext);
         end else begin
            s4_set_in[i] = v_ext <= lvl_ext[i];
            s4_clr_in[i] = v_ext > (lvl_ext[i] + hyst_ext);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= cmd_data.kind;
      s1_prod_ff  <= s1_prod_in;
      s2_kind_ff  <= s1_kind_ff;
      s2_clamp_ff <= s2_clamp_in;
      s3_kind_ff  <= s2_kind_ff;
      s3_value_ff <= s3_value_in;
      s4_kind_ff  <= s3_kind_ff;
      s4_value_ff <= s3_value_ff;
      s4_set_ff   <= s4_set_in;
      s4_clr_ff   <= s4_clr_in;
   end

   // commit: sensor flags and alarm state, one item per cycle
   logic                      avail_ff, avail_in;
   logic                      func_ff, func_in;
   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [ALARMS-1:0]         alarm_ff, alarm_in;
   logic [ALARMS-1:0]         changed;
   status_type                status;
   rsp_type                   res_entry;

   always_comb begin
      avail_in = avail_ff;
      func_in  = func_ff;
      valid_in = valid_ff;
      value_in = value_ff;
      alarm_in = alarm_ff;
      status   = ST_OK;
      unique case (s4_kind_ff)
         KIND_COMPL: begin
            status = ST_COMPL;
         end
         KIND_DECERR: begin
            status   = ST_DECODE;
            func_in  = 1'b0;
            valid_in = 1'b0;
            value_in = '0;
         end
         KIND_DISABLED, KIND_UNAVAIL: begin
            avail_in = s4_kind_ff == KIND_DISABLED;
            func_in  = 1'b0;
            valid_in = 1'b0;
            value_in = '0;
         end
         KIND_BADSIZE: begin
            avail_in = 1'b1;
            func_in  = 1'b1;
            valid_in = 1'b0;
            value_in = '0;
         end
         KIND_CONVERT: begin
            avail_in = 1'b1;
            func_in  = 1'b1;
            valid_in = 1'b1;
            value_in = s4_value_ff;
            for (int i = 0; i < ALARMS; i++) begin
               if (enable_ff[i]) begin
                  alarm_in[i] = s4_set_ff[i] || (!s4_clr_ff[i] && alarm_ff[i]);
               end
            end
         end
         default: begin
            status = ST_DECODE;
         end
      endcase
      changed = alarm_in ^ alarm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= 1'b0;
         func_ff  <= 1'b0;
         valid_ff <= 1'b0;
         value_ff <= '0;
         alarm_ff <= '0;
      end else if (s4_vld_ff) begin
         avail_ff <= avail_in;
         func_ff  <= func_in;
         valid_ff <= valid_in;
         value_ff <= value_in;
         alarm_ff <= alarm_in;
      end
   end

   always_comb begin
      res_entry.status          = status;
      res_entry.available       = avail_in;
      res_entry.functional      = func_in;
      res_entry.value_valid     = valid_in;
      res_entry.value           = value_in;
      res_entry.warn_high_alarm = alarm_in[ALM_WARN_HIGH];
      res_entry.warn_low_alarm  = alarm_in[ALM_WARN_LOW];
      res_entry.crit_high_alarm = alarm_in[ALM_CRIT_HIGH];
      res_entry.crit_low_alarm  = alarm_in[ALM_CRIT_LOW];
      res_entry.alarm_changed   = changed;
   end

   // result queue
   rsp_type              res_mem_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0] res_wr_ff, res_wr_in;
   logic [RES_PTR_W-1:0] res_rd_ff, res_rd_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;

   assign rsp_empty = res_cnt_ff == '0;
   assign rsp_data  = res_mem_ff[res_rd_ff];

   always_comb begin
      res_wr_in  = s4_vld_ff ? res_wr_ff + RES_PTR_W'(1) : res_wr_ff;
      res_rd_in  = res_pop ? res_rd_ff + RES_PTR_W'(1) : res_rd_ff;
      res_cnt_in = res_cnt_ff + RES_CNT_W'(s4_vld_ff) - RES_CNT_W'(res_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff  <= '0;
         res_rd_ff  <= '0;
         res_cnt_ff <= '0;
      end else begin
         res_wr_ff  <= res_wr_in;
         res_rd_ff  <= res_rd_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_vld_ff) begin
         res_mem_ff[res_wr_ff] <= res_entry;
      end
   end

   `SRTM_ASSERT(a_bk_credit, held_ff <= RES_CNT_W'(RES_DEPTH), "issue credit beyond result queue depth")
   `SRTM_ASSERT(a_bk_occupancy, res_cnt_ff <= held_ff, "result queue holds more than was issued")
   `SRTM_ASSERT_NEVER(a_bk_overflow, s4_vld_ff && (res_cnt_ff == RES_CNT_W'(RES_DEPTH)), "result written into a full queue")
   `SRTM_ASSERT_NEVER(a_bk_mask, s4_vld_ff && ((changed & ~enable_ff) != '0), "disabled alarm toggled")

endmodule

// ===== rtl/sensor_reading_threshold_monitor.sv =====
// Sensor reading threshold monitor: top level wiring front end, queue and back end.
// Depends on srtm_pkg, srtm_front, srtm_queue and srtm_back.
`timescale 1ns / 1ps

// Takes one sensor reading response per clock while req_full is low and
// returns one result per response, in order. The product with gain is
// formed during its cycle at the head of the four-entry front queue, then
// clamp, bias add with saturation, threshold compares, and flag and alarm
// commit follow as registered stages in that order. Throughput is one item
// per clock while the result queue has room, with the alarm and flag update
// done in the commit stage for each item. The back end issues only while its
// eight-entry result queue has room for everything in flight, so a stalled
// consumer backs up into the front queue and then raises req_full.
// Configuration writes are always taken (csr_ready is tied high) and must
// be made while the block is idle.
module sensor_reading_threshold_monitor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  srtm_pkg::req_type                req_data,
   output logic                             req_full,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output srtm_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  srtm_pkg::csr_index_type          csr_index,
   input  logic [srtm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import srtm_pkg::*;

   logic    q_push, q_full, cmd_valid, cmd_pop;
   cmd_type q_data, cmd_data;

   assign csr_ready = 1'b1;

   srtm_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_data),
      .q_full   (q_full)
   );

   srtm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .pop       (cmd_pop)
   );

   srtm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sensor_reading_threshold_monitor.
// Depends on srtm_pkg and the block RTL. It predicts every result in-line and
// compares each popped transaction field by field.

module tb;
   import srtm_pkg::*;

   localparam longint VALUE_MAX     = (longint'(1) <<< (VALUE_W - 1)) - 1;
   localparam longint VALUE_MIN     = -(longint'(1) <<< (VALUE_W - 1));
   localparam longint PRODUCT_LIMIT = longint'(1) <<< 61;
   localparam longint HYST_MAX      = (longint'(1) <<< HYST_W) - 1;
   localparam longint ONE_UNIT      = longint'(1) <<< FRAC_BITS;
   localparam int     RANDOM_PHASES = 10;
   localparam int     PHASE_ITEMS   = 150;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     PRINT_LIMIT   = 30;

   typedef struct {
      longint            gain;
      longint            bias;
      longint            hyst;
      longint            warn_high;
      longint            warn_low;
      longint            crit_high;
      longint            crit_low;
      logic [ALARMS-1:0] enable;
   } settings_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   req_type               req_data  = '0;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_GAIN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit idle_on  = 1'b0;
   int pop_hold = 0;

   int      error_count  = 0;
   int      result_count = 0;
   rsp_type expected_results[$];

   // predicted configuration and sensor state
   longint            cfg_gain;
   longint            cfg_bias;
   longint            cfg_hyst;
   longint            cfg_level[ALARMS];
   logic [ALARMS-1:0] cfg_enable;
   logic              sensor_available;
   logic              sensor_functional;
   logic              reading_valid;
   longint            reading_value;
   logic [ALARMS-1:0] alarm_state;

   sensor_reading_threshold_monitor DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic void reset_model();
      cfg_gain   = longint'(GAIN_RESET);
      cfg_bias   = 0;
      cfg_hyst   = 0;
      foreach (cfg_level[i]) cfg_level[i] = 0;
      cfg_enable = '0;
      sensor_available  = 1'b0;
      sensor_functional = 1'b0;
      reading_valid     = 1'b0;
      reading_value     = 0;
      alarm_state       = '0;
   endfunction

   function automatic void apply_csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] word);
      case (idx)
         CSR_GAIN:      cfg_gain = longint'($signed(word[GAIN_W-1:0]));
         CSR_BIAS:      cfg_bias = longint'($signed(word));
         CSR_HYST:      cfg_hyst = longint'(word[HYST_W-1:0]);
         CSR_WARN_HIGH: cfg_level[ALM_WARN_HIGH] = longint'($signed(word));
         CSR_WARN_LOW:  cfg_level[ALM_WARN_LOW] = longint'($signed(word));
         CSR_CRIT_HIGH: cfg_level[ALM_CRIT_HIGH] = longint'($signed(word));
         CSR_CRIT_LOW:  cfg_level[ALM_CRIT_LOW] = longint'($signed(word));
         CSR_ENABLE:    cfg_enable = word[ALARMS-1:0];
         default: ;
      endcase
   endfunction

   function automatic longint widen_reading(size_type sz, logic [RAW_W-1:0] raw);
      case (sz)
         SZ_U8:   return longint'(raw[7:0]);
         SZ_S8:   return longint'($signed(raw[7:0]));
         SZ_U16:  return longint'(raw[15:0]);
         SZ_S16:  return longint'($signed(raw[15:0]));
         SZ_U32:  return longint'(raw);
         default: return longint'($signed(raw));
      endcase
   endfunction

   // product clamps at 2^61 before the bias add, then the sum saturates to 48 bits
   function automatic longint scale_reading(longint r, longint g, longint b);
      longint p;
      p = r * g;
      if (p > PRODUCT_LIMIT) p = PRODUCT_LIMIT;
      if (p < -PRODUCT_LIMIT) p = -PRODUCT_LIMIT;
      p = p + b;
      if (p > VALUE_MAX) p = VALUE_MAX;
      if (p < VALUE_MIN) p = VALUE_MIN;
      return p;
   endfunction

   function automatic logic threshold_alarm(int which, logic prev, longint v);
      longint lvl;
      lvl = cfg_level[which];
      if (HIGH_MASK[which]) begin
         if (v >= lvl) return 1'b1;
         if (v < lvl - cfg_hyst) return 1'b0;
      end else begin
         if (v <= lvl) return 1'b1;
         if (v > lvl + cfg_hyst) return 1'b0;
      end
      return prev;
   endfunction

   function automatic rsp_type predict_reading(req_type item);
      rsp_type           want;
      logic [ALARMS-1:0] next_alarms;
      logic [ALARMS-1:0] changed;
      changed     = '0;
      want        = '0;
      want.status = ST_OK;
      if (item.response_status == RS_COMPL) begin
         want.status = ST_COMPL;
      end else if (item.response_status != RS_OK) begin
         // reserved code behaves as a decode failure
         want.status       = ST_DECODE;
         sensor_functional = 1'b0;
         reading_valid     = 1'b0;
         reading_value     = 0;
      end else if (item.operational_state != OP_ENABLED) begin
         sensor_available  = (item.operational_state == OP_DISABLED);
         sensor_functional = 1'b0;
         reading_valid     = 1'b0;
         reading_value     = 0;
      end else begin
         sensor_available  = 1'b1;
         sensor_functional = 1'b1;
         if (item.data_size == SZ_BAD6 || item.data_size == SZ_BAD7) begin
            reading_valid = 1'b0;
            reading_value = 0;
         end else begin
            reading_value = scale_reading(
               widen_reading(size_type'(item.data_size), item.reading_raw), cfg_gain, cfg_bias);
            reading_valid = 1'b1;
            next_alarms   = alarm_state;
            for (int i = 0; i < ALARMS; i++)
               if (cfg_enable[i])
                  next_alarms[i] = threshold_alarm(i, alarm_state[i], reading_value);
            changed     = next_alarms ^ alarm_state;
            alarm_state = next_alarms;
         end
      end
      want.available       = sensor_available;
      want.functional      = sensor_functional;
      want.value_valid     = reading_valid;
      want.value           = reading_valid ? reading_value[VALUE_W-1:0] : '0;
      want.warn_high_alarm = alarm_state[ALM_WARN_HIGH];
      want.warn_low_alarm  = alarm_state[ALM_WARN_LOW];
      want.crit_high_alarm = alarm_state[ALM_CRIT_HIGH];
      want.crit_low_alarm  = alarm_state[ALM_CRIT_LOW];
      want.alarm_changed   = changed;
      return want;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: result %0d %s mismatch: got %0h, expected %0h",
                  $time, result_count, what, got, want);
   endtask

   task automatic check_result(rsp_type got, rsp_type want);
      if (got.status != want.status)
         report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.available != want.available)
         report_mismatch("available", 64'(got.available), 64'(want.available));
      if (got.functional != want.functional)
         report_mismatch("functional", 64'(got.functional), 64'(want.functional));
      if (got.value_valid != want.value_valid)
         report_mismatch("value_valid", 64'(got.value_valid), 64'(want.value_valid));
      if (got.value != want.value)
         report_mismatch("value", 64'(got.value), 64'(want.value));
      if (got.warn_high_alarm != want.warn_high_alarm)
         report_mismatch("warn_high_alarm", 64'(got.warn_high_alarm),
                         64'(want.warn_high_alarm));
      if (got.warn_low_alarm != want.warn_low_alarm)
         report_mismatch("warn_low_alarm", 64'(got.warn_low_alarm),
                         64'(want.warn_low_alarm));
      if (got.crit_high_alarm != want.crit_high_alarm)
         report_mismatch("crit_high_alarm", 64'(got.crit_high_alarm),
                         64'(want.crit_high_alarm));
      if (got.crit_low_alarm != want.crit_low_alarm)
         report_mismatch("crit_low_alarm", 64'(got.crit_low_alarm),
                         64'(want.crit_low_alarm));
      if (got.alarm_changed != want.alarm_changed)
         report_mismatch("alarm_changed", 64'(got.alarm_changed), 64'(want.alarm_changed));
   endtask

   // result side: check the popped transaction, then choose pop for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_results.size() == 0)
            report_mismatch("unexpected result", 64'(rsp_data), '0);
         else
            check_result(rsp_data, expected_results.pop_front());
         result_count++;
      end
      if (pop_hold > 0) begin
         pop_hold--;
         rsp_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         pop_hold = $urandom_range(0, 3);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // push stays high after acceptance so back-to-back items need no re-raise
   task automatic send_reading(req_type item);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_results.push_back(predict_reading(item));
   endtask

   task automatic wait_for_results();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // registers only change with the block idle; unused upper bits get noise
   task automatic program_settings(settings_type s);
      logic [CSR_DATA_W-1:0] words[8];
      req_push <= 1'b0;
      wait_for_results();
      words[CSR_GAIN]      = {16'($urandom), s.gain[GAIN_W-1:0]};
      words[CSR_BIAS]      = s.bias[CSR_DATA_W-1:0];
      words[CSR_HYST]      = {1'($urandom), s.hyst[HYST_W-1:0]};
      words[CSR_WARN_HIGH] = s.warn_high[CSR_DATA_W-1:0];
      words[CSR_WARN_LOW]  = s.warn_low[CSR_DATA_W-1:0];
      words[CSR_CRIT_HIGH] = s.crit_high[CSR_DATA_W-1:0];
      words[CSR_CRIT_LOW]  = s.crit_low[CSR_DATA_W-1:0];
      words[CSR_ENABLE]    = {12'($urandom), 32'($urandom), s.enable};
      csr_valid <= 1'b1;
      for (int i = 0; i < 8; i++) begin
         csr_index <= csr_index_type'(i);
         csr_wdata <= words[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         apply_csr_write(csr_index_type'(i), words[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic settings_type default_settings();
      settings_type s;
      s.gain      = longint'(GAIN_RESET);
      s.bias      = 0;
      s.hyst      = 0;
      s.warn_high = 0;
      s.warn_low  = 0;
      s.crit_high = 0;
      s.crit_low  = 0;
      s.enable    = '0;
      return s;
   endfunction

   function automatic req_type make_req(resp_code_type rs, op_state_type op, size_type sz,
                                        logic [RAW_W-1:0] raw);
      req_type item;
      item.response_status   = rs;
      item.operational_state = op;
      item.data_size         = sz;
      item.reading_raw       = raw;
      return item;
   endfunction

   // mostly clean enabled readings of the phase's size, the rest any code mix
   function automatic req_type random_reading(size_type pref);
      req_type item;
      item.reading_raw = $urandom;
      if ($urandom_range(0, 99) < 80) begin
         item.response_status   = RS_OK;
         item.operational_state = OP_ENABLED;
         item.data_size = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(SZ_U8, SZ_S32)) : pref;
      end else begin
         item.response_status   = 2'($urandom);
         item.operational_state = 2'($urandom);
         item.data_size         = 3'($urandom);
      end
      return item;
   endfunction

   // thresholds land on converted readings of the same size so alarms toggle
   function automatic settings_type random_settings(size_type pref);
      settings_type s;
      longint       span;
      longint       mag;
      case ($urandom_range(0, 2))
         0:       s.gain = longint'(GAIN_RESET);
         1:       s.gain = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         default: s.gain = longint'($signed($urandom));
      endcase
      if ($urandom_range(0, 1))
         s.bias = longint'($signed({16'($urandom), 32'($urandom)}));
      else
         s.bias = longint'($signed($urandom));
      s.warn_high = scale_reading(widen_reading(pref, $urandom), s.gain, s.bias);
      s.warn_low  = scale_reading(widen_reading(pref, $urandom), s.gain, s.bias);
      s.crit_high = scale_reading(widen_reading(pref, $urandom), s.gain, s.bias);
      s.crit_low  = scale_reading(widen_reading(pref, $urandom), s.gain, s.bias);
      case (pref)
         SZ_U8, SZ_S8:   span = 16;
         SZ_U16, SZ_S16: span = 4096;
         default:        span = longint'(1) <<< 28;
      endcase
      mag    = (s.gain < 0) ? -s.gain : s.gain;
      s.hyst = mag * longint'($urandom_range(0, 32'(span)));
      if (s.hyst > HYST_MAX) s.hyst = HYST_MAX;
      s.enable = 4'($urandom);
      return s;
   endfunction

   task automatic test_response_kinds();
      send_reading(make_req(RS_COMPL, OP_ENABLED, SZ_U8, 32'h0000_00FF));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_U8, 32'hA5A5_A5FF));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S8, 32'h1234_5680));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_U16, 32'h5A5A_FFFF));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'hFFFF_8000));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_U32, 32'hFFFF_FFFF));
      send_reading(make_req(RS_COMPL, OP_UNAVAIL, SZ_BAD7, 32'h0000_0000));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S32, 32'h8000_0000));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_BAD6, 32'h0000_0010));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S8, 32'h0000_007F));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_BAD7, 32'hFFFF_FFFF));
      send_reading(make_req(RS_DECODE, OP_ENABLED, SZ_U8, 32'h0000_0001));
      send_reading(make_req(RS_RSVD, OP_DISABLED, SZ_S16, 32'h0000_0002));
      send_reading(make_req(RS_OK, OP_DISABLED, SZ_U8, 32'h0000_0003));
      send_reading(make_req(RS_OK, OP_UNAVAIL, SZ_U8, 32'h0000_0004));
      send_reading(make_req(RS_OK, OP_UNAVAIL2, SZ_U8, 32'h0000_0005));
   endtask

   task automatic test_saturation();
      settings_type s;
      s      = default_settings();
      s.gain = 2147483647;
      s.bias = VALUE_MAX;
      program_settings(s);
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_U32, 32'hFFFF_FFFF));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S32, 32'h8000_0000));
      s.gain = -2147483648;
      s.bias = VALUE_MIN;
      program_settings(s);
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_U32, 32'hFFFF_FFFF));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S32, 32'h8000_0000));
   endtask

   // warn at +/-100, crit at +/-200, band of 10: set, hold inside band, clear
   task automatic test_hysteresis_alarms();
      settings_type s;
      s           = default_settings();
      s.warn_high = 100 * ONE_UNIT;
      s.warn_low  = -100 * ONE_UNIT;
      s.crit_high = 200 * ONE_UNIT;
      s.crit_low  = -200 * ONE_UNIT;
      s.hyst      = 10 * ONE_UNIT;
      s.enable    = 4'hF;
      program_settings(s);
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'(150)));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'(95)));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'(85)));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'(250)));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'(195)));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'(-250)));
      send_reading(make_req(RS_OK, OP_ENABLED, SZ_S16, 32'(-195)));
   endtask

   task automatic test_random_phases();
      settings_type s;
      size_type     pref;
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         pref = size_type'($urandom_range(SZ_U8, SZ_S32));
         if (k == 0) begin
            s           = default_settings();
            s.gain      = 2147483647;
            s.bias      = VALUE_MAX;
            s.hyst      = HYST_MAX;
            s.warn_high = VALUE_MAX;
            s.warn_low  = VALUE_MIN;
            s.crit_high = VALUE_MAX;
            s.crit_low  = VALUE_MIN;
            s.enable    = 4'hF;
         end else if (k == 1) begin
            s        = default_settings();
            s.gain   = -2147483648;
            s.bias   = VALUE_MIN;
            s.enable = 4'hF;
         end else begin
            s = random_settings(pref);
         end
         program_settings(s);
         // final phase runs at full rate on both sides
         idle_on = (k < RANDOM_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_reading(random_reading(pref));
      end
   endtask

   initial begin
      reset_model();
      idle_on = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_response_kinds();
      test_saturation();
      test_hysteresis_alarms();
      test_random_phases();
      req_push <= 1'b0;
      wait_for_results();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
